// ----- src/sha1_stream_hasher_core_defines.svh -----
// Assertion shorthands shared by the RTL. Each expects clk and rst_n in scope.
`ifndef SHA1_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_STREAM_HASHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SHA1SH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA1SH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sha1sh_pkg.sv -----
package sha1sh_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 4;

    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    // INIT_CHAIN[0] is H0
    localparam logic [4:0][31:0] INIT_CHAIN = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // one queued word: byte, byte-present flag, end-of-message flag
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } sha1sh_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_COMP,
        ST_FINAL,
        ST_OUT
    } sha1sh_state_t;

    // round function plus round constant, picked by round number
    function automatic logic [63:0] sha1_fk(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        logic [31:0] k;
        begin
            if (rnd < 7'd20)
            begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end
            else if (rnd < 7'd40)
            begin
                f = b ^ c ^ d;
                k = K_R1;
            end
            else if (rnd < 7'd60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            return {f, k};
        end
    endfunction

endpackage

// ----- src/sha1sh_queue.sv -----
module sha1sh_queue
    import sha1sh_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sha1sh_cmd_t push_cmd,
    output logic        full,
    output logic        pop_valid,
    input  logic        pop,
    output sha1sh_cmd_t pop_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sha1sh_cmd_t    mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/sha1sh_front.sv -----
module sha1sh_front
    import sha1sh_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // msg_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        q_full,
    output logic        q_push,
    output sha1sh_cmd_t q_cmd
);

    // words with neither a byte nor an end mark change nothing: drop them
    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full && (s_tuser || s_tlast);
    assign q_cmd.data  = s_tdata;
    assign q_cmd.has   = s_tuser;
    assign q_cmd.last  = s_tlast;

endmodule

// ----- src/sha1sh_back.sv -----
`include "sha1_stream_hasher_core_defines.svh"

module sha1sh_back
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  sha1sh_cmd_t q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);

    sha1sh_state_t  state_reg, state_next;
    sha1sh_state_t  ret_reg, ret_next;
    logic [31:0]    w_reg [16];
    logic [4:0][31:0] chain_reg;
    logic [31:0]    a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]     round_reg;
    logic [5:0]     fill_reg, fill_next;
    logic [60:0]    total_reg, total_next;
    logic [2:0]     idx_reg, idx_next;
    logic           out_valid_reg;
    logic [31:0]    out_word_reg;
    logic [2:0]     out_idx_reg;
    logic           out_last_reg;

    logic           put_en;
    logic [7:0]     put_val;
    logic           len_en;
    logic           comp_start;
    logic           comp_step;
    logic           final_add;
    logic           out_load;
    logic           chain_clear;
    logic           slot_free;
    logic [63:0]    fk;
    logic [31:0]    t_sum;
    logic [31:0]    w_new;
    logic [31:0]    w_mix;
    logic [63:0]    bit_len;

    assign slot_free = !out_valid_reg || m_tready;
    assign fk        = sha1_fk(round_reg, b_reg, c_reg, d_reg);
    assign t_sum     = {a_reg[26:0], a_reg[31:27]} + fk[63:32] + e_reg + fk[31:0] + w_reg[0];
    assign w_mix     = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new     = {w_mix[30:0], w_mix[31]};
    assign bit_len   = {total_reg, 3'b000};

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        put_en      = 1'b0;
        put_val     = 8'h00;
        len_en      = 1'b0;
        comp_start  = 1'b0;
        comp_step   = 1'b0;
        final_add   = 1'b0;
        out_load    = 1'b0;
        chain_clear = 1'b0;
        q_pop       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.has)
                    begin
                        put_en     = 1'b1;
                        put_val    = q_cmd.data;
                        fill_next  = fill_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    if (q_cmd.has && fill_reg == FILL_LAST)
                    begin
                        comp_start = 1'b1;
                        ret_next   = q_cmd.last ? ST_PAD80 : ST_IDLE;
                        state_next = ST_COMP;
                    end
                    else if (q_cmd.last)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                put_en    = 1'b1;
                put_val   = PAD_BYTE;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST)
                begin
                    comp_start = 1'b1;
                    ret_next   = ST_PADZ;
                    state_next = ST_COMP;
                end
                else if (fill_reg == FILL_LEN - 1'b1)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (fill_reg == FILL_LEN)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    put_en    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == FILL_LAST)
                    begin
                        comp_start = 1'b1;
                        ret_next   = ST_PADZ;
                        state_next = ST_COMP;
                    end
                end
            end
            ST_LEN:
            begin
                len_en     = 1'b1;
                fill_next  = '0;
                comp_start = 1'b1;
                ret_next   = ST_OUT;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                comp_step = 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                final_add  = 1'b1;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg == WORD_LAST)
                    begin
                        chain_clear = 1'b1;
                        total_next  = '0;
                        idx_next    = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            round_reg     <= '0;
            chain_reg     <= INIT_CHAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            if (comp_start)
            begin
                round_reg <= '0;
            end
            else if (comp_step)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (chain_clear)
            begin
                chain_reg <= INIT_CHAIN;
            end
            else if (final_add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working variables, message window, output payload
    always_ff @(posedge clk)
    begin
        if (comp_start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (comp_step)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end

        // window holds W[r..r+15]; shifting in W[r+16] each round
        if (comp_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        else if (len_en)
        begin
            w_reg[14] <= bit_len[63:32];
            w_reg[15] <= bit_len[31:0];
        end
        else if (put_en)
        begin
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= put_val;
        end

        if (out_load)
        begin
            out_word_reg <= chain_reg[idx_reg];
            out_idx_reg  <= idx_reg;
            out_last_reg <= (idx_reg == WORD_LAST);
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_idx_reg;
    assign out_last  = out_last_reg;

    `SHA1SH_ASSERT_IMP(a_round_range, state_reg == ST_COMP, round_reg <= ROUND_LAST,
                       "round count past 79")
    `SHA1SH_ASSERT_IMP(a_len_fill, state_reg == ST_LEN, fill_reg == FILL_LEN,
                       "length written at wrong fill")
    `SHA1SH_ASSERT_IMP(a_idle_idx, state_reg == ST_IDLE, idx_reg == '0,
                       "word index not cleared in idle")
    `SHA1SH_ASSERT_NEXT(a_chain_reinit, out_load && idx_reg == WORD_LAST,
                        (state_reg == ST_IDLE) && (chain_reg == INIT_CHAIN) && (total_reg == '0),
                        "chain not reset after digest")

endmodule

// ----- src/sha1_stream_hasher_core.sv -----
// Streaming SHA-1 hasher. Each input word carries at most one message byte
// (s_tuser = byte present) and s_tlast ends the message after that byte; a word
// with s_tuser low and s_tlast high closes a message with no further byte, so
// an empty message is allowed. On message end the core pads, appends the 64-bit
// bit length (wrapping modulo 2^64), and emits five digest words, H0 first,
// with m_tlast on the fifth; it then starts a fresh message from the initial
// chaining values. In the back end each byte goes into the block buffer, and
// the 64th byte of a block starts a compression: 80 rounds at one round per
// cycle through the single round unit, then the chaining add. On message end
// the core writes the 0x80 pad byte, then zero pad bytes until the fill
// reaches 56 (up to 64 pad bytes in all), then the length, running one or two
// compressions, and sends the five digest words. The input queue lets bytes
// keep arriving while a block compresses until it fills.
module sha1_stream_hasher_core
    import sha1sh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    sha1sh_cmd_t  push_cmd;
    sha1sh_cmd_t  pop_cmd;
    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    logic [31:0]  digest_word;
    logic [2:0]   word_index;

    // front: takes input words and drops ones that carry nothing
    sha1sh_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    sha1sh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (pop_cmd)
    );

    // back: block packing, padding, compression, digest output
    sha1sh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_word  (digest_word),
        .out_index (word_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};

endmodule
